// ===== hdl/btsd_pkg.sv =====
// btsd_pkg: shared types and constants of the ber tlv stream decoder
// no dependencies; used by the decoder modules, the checker and the bench
package btsd_pkg;

  localparam logic [7:0] TagInteger = 8'h02;
  localparam logic [7:0] TagOctets  = 8'h04;
  localparam logic [7:0] TagNull    = 8'h05;

  localparam logic [7:0] LongFormBit = 8'h80;
  localparam logic [6:0] LenCountMask = 7'h7F;

  localparam logic [1:0] PhTag      = 2'd0;
  localparam logic [1:0] PhLenFirst = 2'd1;
  localparam logic [1:0] PhLenMore  = 2'd2;
  localparam logic [1:0] PhContent  = 2'd3;

  typedef enum logic [2:0] {
    EvInt    = 3'd0,
    EvSByte  = 3'd1,
    EvSEmpty = 3'd2,
    EvNull   = 3'd3,
    EvOther  = 3'd4,
    EvLenErr = 3'd5,
    EvIntErr = 3'd6,
    EvStrErr = 3'd7
  } event_e;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  elem_tag;
    logic [31:0] value;
    logic [31:0] elem_length;
    logic        last;
  } res_t;

endpackage

// ===== hdl/btsd_ifs.sv =====
// btsd channel interfaces: input byte, result and configuration write channels
// valid/ready handshake; no package dependencies
interface btsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface btsd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  elem_tag;
  logic [31:0] value;
  logic [31:0] elem_length;
  logic        last;
  modport source (output valid, output event_res, output elem_tag, output value,
                  output elem_length, output last, input ready);
  modport sink (input valid, input event_res, input elem_tag, input value,
                input elem_length, input last, output ready);
endinterface

interface btsd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_string_len;
  modport source (output valid, output max_string_len, input ready);
  modport sink (input valid, input max_string_len, output ready);
endinterface

// ===== hdl/btsd_core.sv =====
// btsd_core: element parsing state and per-byte result decode
// depends on btsd_pkg
module btsd_core #(
  parameter int MAX_FIELD_BYTES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         in_byte_i,
  input  logic [31:0]        max_len_i,
  output logic               emit_o,
  output btsd_pkg::res_t     res_o
);

  localparam int LblW = $clog2(MAX_FIELD_BYTES + 1);

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      tag_q, tag_d;
  logic [LblW-1:0] lbl_q, lbl_d, lbl_dec;
  logic [31:0]     dlen_q, dlen_d;
  logic [31:0]     cl_q, cl_d, cl_dec;
  logic [31:0]     acc_q, acc_d, acc_n;
  logic            disc_q, disc_d;
  logic [31:0]     len_new;
  logic            do_begin;
  logic            done;
  logic [6:0]      n_len;

  always_comb begin
    phase_d  = phase_q;
    tag_d    = tag_q;
    lbl_d    = lbl_q;
    dlen_d   = dlen_q;
    cl_d     = cl_q;
    acc_d    = acc_q;
    disc_d   = disc_q;
    len_new  = dlen_q;
    do_begin = 1'b0;
    emit_o   = 1'b0;
    res_o    = '{event_res: btsd_pkg::EvOther, elem_tag: tag_q, value: '0,
                 elem_length: '0, last: 1'b1};
    n_len    = in_byte_i[6:0] & btsd_pkg::LenCountMask;
    lbl_dec  = (lbl_q != '0) ? lbl_q - LblW'(1) : '0;
    cl_dec   = cl_q - 32'd1;
    done     = (cl_dec == '0);
    acc_n    = {acc_q[23:0], in_byte_i};

    case (phase_q)
      btsd_pkg::PhTag: begin
        tag_d   = in_byte_i;
        dlen_d  = '0;
        phase_d = btsd_pkg::PhLenFirst;
      end
      btsd_pkg::PhLenFirst: begin
        if ((in_byte_i & btsd_pkg::LongFormBit) == 8'h00) begin
          len_new  = {24'h0, in_byte_i};
          do_begin = 1'b1;
        end else if (n_len > 7'(MAX_FIELD_BYTES)) begin
          phase_d          = btsd_pkg::PhTag;
          dlen_d           = '0;
          emit_o           = 1'b1;
          res_o.event_res  = btsd_pkg::EvLenErr;
        end else begin
          dlen_d = '0;
          if (n_len == '0) begin
            len_new  = '0;
            do_begin = 1'b1;
          end else begin
            lbl_d   = LblW'(n_len);
            phase_d = btsd_pkg::PhLenMore;
          end
        end
      end
      btsd_pkg::PhLenMore: begin
        len_new = {dlen_q[23:0], in_byte_i};
        dlen_d  = len_new;
        lbl_d   = lbl_dec;
        if (lbl_dec == '0) begin
          do_begin = 1'b1;
        end
      end
      btsd_pkg::PhContent: begin
        if (cl_q == '0) begin
          phase_d = btsd_pkg::PhTag;
        end else begin
          cl_d = cl_dec;
          if (done) begin
            phase_d = btsd_pkg::PhTag;
          end
          res_o.elem_length = dlen_q;
          if (disc_q) begin
            if (done) begin
              disc_d = 1'b0;
            end
          end else if (tag_q == btsd_pkg::TagInteger) begin
            acc_d = acc_n;
            if (done) begin
              emit_o          = 1'b1;
              res_o.event_res = btsd_pkg::EvInt;
              res_o.value     = acc_n;
            end
          end else if (tag_q == btsd_pkg::TagOctets) begin
            emit_o          = 1'b1;
            res_o.event_res = btsd_pkg::EvSByte;
            res_o.value     = {24'h0, in_byte_i};
            res_o.last      = done;
          end else if (done) begin
            emit_o          = 1'b1;
            res_o.event_res = (tag_q == btsd_pkg::TagNull) ? btsd_pkg::EvNull
                                                           : btsd_pkg::EvOther;
          end
        end
      end
      default: begin
        phase_d = btsd_pkg::PhTag;
      end
    endcase

    // start of contents once the length is known
    if (do_begin) begin
      dlen_d            = len_new;
      cl_d              = len_new;
      acc_d             = '0;
      disc_d            = 1'b0;
      res_o.elem_length = len_new;
      if (tag_q == btsd_pkg::TagInteger && len_new > 32'(MAX_FIELD_BYTES)) begin
        disc_d          = 1'b1;
        phase_d         = btsd_pkg::PhContent;
        emit_o          = 1'b1;
        res_o.event_res = btsd_pkg::EvIntErr;
      end else if (tag_q == btsd_pkg::TagOctets && len_new > max_len_i) begin
        disc_d          = (len_new != '0);
        phase_d         = (len_new != '0) ? btsd_pkg::PhContent : btsd_pkg::PhTag;
        emit_o          = 1'b1;
        res_o.event_res = btsd_pkg::EvStrErr;
      end else if (len_new == '0) begin
        phase_d = btsd_pkg::PhTag;
        emit_o  = 1'b1;
        if (tag_q == btsd_pkg::TagInteger) begin
          res_o.event_res = btsd_pkg::EvInt;
        end else if (tag_q == btsd_pkg::TagOctets) begin
          res_o.event_res = btsd_pkg::EvSEmpty;
        end else if (tag_q == btsd_pkg::TagNull) begin
          res_o.event_res = btsd_pkg::EvNull;
        end else begin
          res_o.event_res = btsd_pkg::EvOther;
        end
      end else begin
        phase_d = btsd_pkg::PhContent;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= btsd_pkg::PhTag;
      tag_q   <= '0;
      lbl_q   <= '0;
      dlen_q  <= '0;
      cl_q    <= '0;
      acc_q   <= '0;
      disc_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      lbl_q   <= lbl_d;
      dlen_q  <= dlen_d;
      cl_q    <= cl_d;
      acc_q   <= acc_d;
      disc_q  <= disc_d;
    end
  end

endmodule

// ===== hdl/btsd_outreg.sv =====
// btsd_outreg: result register between the decode logic and the result channel
// depends on btsd_pkg
module btsd_outreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           emit_i,
  input  btsd_pkg::res_t res_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output btsd_pkg::res_t res_o
);

  logic           valid_q;
  btsd_pkg::res_t res_q;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept_i && emit_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/ber_tlv_stream_decoder.sv =====
// ber_tlv_stream_decoder: top level of the ber tlv stream decoder
// depends on btsd_pkg, btsd_ifs, btsd_core and btsd_outreg
//
// usage:
//   in_i carries one byte of a stream of back-to-back ber elements per item
//   (tag, short or long length, contents). out_o gives at most one result
//   item per input byte: integer value, string byte, empty string, null,
//   other element done, or one of three error codes, with the element tag
//   and decoded length. cfg_i writes max_string_len and is always ready;
//   write it only while no item is in flight.
//   a result is registered and shows on out_o in the cycle after the byte
//   that causes it is accepted. in_i takes one byte per cycle while the one-entry
//   result register can take a result; btsd_core updates its state per byte.
//   in_i.ready is high whenever the result register is empty or being
//   taken; when the receiver stalls with a result held, input stalls too.
//   reset clears the parse state to expect a tag, empties the result
//   register and sets max_string_len to all ones.
module ber_tlv_stream_decoder #(
  parameter int MAX_FIELD_BYTES = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  btsd_in_if.sink    in_i,
  btsd_out_if.source out_o,
  btsd_cfg_if.sink   cfg_i
);

  logic           accept;
  logic           emit;
  logic           in_ready;
  logic [31:0]    max_len_q;
  btsd_pkg::res_t res;
  btsd_pkg::res_t res_out;

  assign accept      = in_i.valid && in_ready;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_string_len;
    end
  end

  btsd_core #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_byte_i (in_i.in_byte),
    .max_len_i (max_len_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  btsd_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .emit_i      (emit),
    .res_i       (res),
    .in_ready_o  (in_ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .res_o       (res_out)
  );

  assign out_o.event_res   = res_out.event_res;
  assign out_o.elem_tag    = res_out.elem_tag;
  assign out_o.value       = res_out.value;
  assign out_o.elem_length = res_out.elem_length;
  assign out_o.last        = res_out.last;

endmodule

// ===== hdl/btsd_checker.sv =====
// btsd_checker: port-level assertions on the ber tlv stream decoder
// depends on btsd_pkg; bound to ber_tlv_stream_decoder below
module btsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  event_res_i,
  input logic [31:0] value_i,
  input logic        last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

  a_result_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i))
    else $error("result without accepted item");

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_res_i == btsd_pkg::EvLenErr ||
                    event_res_i == btsd_pkg::EvIntErr ||
                    event_res_i == btsd_pkg::EvStrErr) |-> last_i)
    else $error("error result not marked last");

  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && event_res_i != btsd_pkg::EvInt &&
    event_res_i != btsd_pkg::EvSByte |-> value_i == '0)
    else $error("nonzero value on valueless result");

endmodule

bind ber_tlv_stream_decoder btsd_checker u_btsd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .event_res_i (out_o.event_res),
  .value_i     (out_o.value),
  .last_i      (out_o.last)
);

// ===== sim/ber_tlv_stream_decoder_test.sv =====
// ber_tlv_stream_decoder_test: self-checking bench that feeds encoded ber element
// streams to the decoder and checks each result item against an in-bench predictor
// depends on btsd_pkg, btsd_ifs and the ber_tlv_stream_decoder rtl
module ber_tlv_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxFieldBytes = 4;
  localparam int CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;

  btsd_in_if  in_if ();
  btsd_out_if out_if ();
  btsd_cfg_if cfg_if ();

  ber_tlv_stream_decoder #(
    .MAX_FIELD_BYTES(MaxFieldBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // decoder state as predicted
  logic [1:0]  ph;
  logic [7:0]  cur_tag;
  logic [2:0]  len_bytes_left;
  logic [31:0] cur_len;
  logic [31:0] bytes_left;
  logic [31:0] acc;
  logic        skipping;
  logic [31:0] max_str_len;

  btsd_pkg::res_t pending_events[$];
  int   fail_count;
  int   bytes_sent;
  int   cycles;
  int   burst_left;
  bit   in_active;

  function automatic bit tlv_start_contents(output btsd_pkg::res_t r);
    r = '0;
    r.elem_tag = cur_tag;
    r.elem_length = cur_len;
    r.last = 1'b1;
    bytes_left = cur_len;
    acc = '0;
    skipping = 1'b0;
    if (cur_tag == btsd_pkg::TagInteger && cur_len > 32'(MaxFieldBytes)) begin
      skipping = (bytes_left != 0);
      ph = skipping ? btsd_pkg::PhContent : btsd_pkg::PhTag;
      r.event_res = btsd_pkg::EvIntErr;
      return 1'b1;
    end
    if (cur_tag == btsd_pkg::TagOctets && cur_len > max_str_len) begin
      skipping = (bytes_left != 0);
      ph = skipping ? btsd_pkg::PhContent : btsd_pkg::PhTag;
      r.event_res = btsd_pkg::EvStrErr;
      return 1'b1;
    end
    if (cur_len == 0) begin
      ph = btsd_pkg::PhTag;
      if (cur_tag == btsd_pkg::TagInteger) r.event_res = btsd_pkg::EvInt;
      else if (cur_tag == btsd_pkg::TagOctets) r.event_res = btsd_pkg::EvSEmpty;
      else if (cur_tag == btsd_pkg::TagNull) r.event_res = btsd_pkg::EvNull;
      else r.event_res = btsd_pkg::EvOther;
      return 1'b1;
    end
    ph = btsd_pkg::PhContent;
    return 1'b0;
  endfunction

  function automatic bit tlv_content_byte(input logic [7:0] b, output btsd_pkg::res_t r);
    bit done;
    r = '0;
    r.elem_tag = cur_tag;
    r.elem_length = cur_len;
    bytes_left = bytes_left - 1;
    done = (bytes_left == 0);
    if (done) ph = btsd_pkg::PhTag;
    if (skipping) begin
      if (done) skipping = 1'b0;
      return 1'b0;
    end
    if (cur_tag == btsd_pkg::TagInteger) begin
      acc = {acc[23:0], b};
      r.event_res = btsd_pkg::EvInt;
      r.value = acc;
      r.last = 1'b1;
      return done;
    end
    if (cur_tag == btsd_pkg::TagOctets) begin
      r.event_res = btsd_pkg::EvSByte;
      r.value = {24'd0, b};
      r.last = done;
      return 1'b1;
    end
    if (!done) return 1'b0;
    r.event_res = (cur_tag == btsd_pkg::TagNull) ? btsd_pkg::EvNull : btsd_pkg::EvOther;
    r.last = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit tlv_step(input logic [7:0] b, output btsd_pkg::res_t r);
    logic [6:0] n;
    r = '0;
    case (ph)
      btsd_pkg::PhTag: begin
        cur_tag = b;
        cur_len = '0;
        ph = btsd_pkg::PhLenFirst;
        return 1'b0;
      end
      btsd_pkg::PhLenFirst: begin
        if ((b & btsd_pkg::LongFormBit) == 0) begin
          cur_len = {24'd0, b};
          return tlv_start_contents(r);
        end
        n = b[6:0] & btsd_pkg::LenCountMask;
        cur_len = '0;
        if (n > 7'(MaxFieldBytes)) begin
          ph = btsd_pkg::PhTag;
          r.event_res = btsd_pkg::EvLenErr;
          r.elem_tag = cur_tag;
          r.last = 1'b1;
          return 1'b1;
        end
        if (n == 0) return tlv_start_contents(r);
        len_bytes_left = 3'(n);
        ph = btsd_pkg::PhLenMore;
        return 1'b0;
      end
      btsd_pkg::PhLenMore: begin
        cur_len = {cur_len[23:0], b};
        if (len_bytes_left > 0) len_bytes_left = len_bytes_left - 1;
        if (len_bytes_left == 0) return tlv_start_contents(r);
        return 1'b0;
      end
      default: begin
        if (bytes_left == 0) begin
          ph = btsd_pkg::PhTag;
          return 1'b0;
        end
        return tlv_content_byte(b, r);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    btsd_pkg::res_t r;
    int gap;
    in_if.valid <= 1'b1;
    in_if.in_byte <= b;
    in_active = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
    if (tlv_step(b, r)) pending_events.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        in_active = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic drain;
    if (in_active) begin
      in_if.valid <= 1'b0;
      in_active = 1'b0;
    end
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [31:0] v);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.max_string_len <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    max_str_len = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_header(input logic [7:0] tag, input logic [31:0] len);
    int n_len;
    int min_n;
    send_byte(tag);
    if (len == 0 && $urandom_range(0, 3) == 0) begin
      send_byte(btsd_pkg::LongFormBit);
    end else if (len < 128 && $urandom_range(0, 2) != 0) begin
      send_byte(len[7:0]);
    end else begin
      min_n = (len > 32'hFF_FFFF) ? 4 : (len > 32'hFFFF) ? 3 : (len > 32'hFF) ? 2 : 1;
      n_len = $urandom_range(min_n, MaxFieldBytes);
      send_byte(btsd_pkg::LongFormBit | 8'(n_len));
      for (int i = n_len - 1; i >= 0; i--) send_byte(8'(len >> (8 * i)));
    end
  endtask

  // keeps any length that noise builds below 256
  function automatic logic [7:0] noise_byte;
    if (ph == btsd_pkg::PhLenMore && len_bytes_left > 1) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_noise;
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(noise_byte());
    while (ph == btsd_pkg::PhLenFirst || ph == btsd_pkg::PhLenMore) send_byte(noise_byte());
  endtask

  task automatic send_random_element;
    int pick;
    logic [7:0] tag;
    logic [31:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 88) begin
      if (pick < 25) begin
        tag = btsd_pkg::TagInteger;
        len = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
      end else if (pick < 50) begin
        tag = btsd_pkg::TagOctets;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      end else if (pick < 62) begin
        tag = btsd_pkg::TagNull;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      end else if (pick < 80) begin
        tag = 8'($urandom_range(0, 255));
        len = $urandom_range(0, 10);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
        send_byte(8'($urandom_range(8'h85, 8'hFF)));
        return;
      end
      send_header(tag, len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_noise();
    end
  endtask

  task automatic test_integers;
    send_seq('{btsd_pkg::TagInteger, 8'h00});
    send_seq('{btsd_pkg::TagInteger, 8'h01, 8'h7F});
    send_seq('{btsd_pkg::TagInteger, 8'h01, 8'h80});
    send_seq('{btsd_pkg::TagInteger, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_seq('{btsd_pkg::TagInteger, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00});
    send_seq('{btsd_pkg::TagInteger, 8'h84, 8'h00, 8'h00, 8'h00, 8'h02, 8'h12, 8'h34});
    send_seq('{btsd_pkg::TagInteger, 8'h05, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
    send_seq('{btsd_pkg::TagInteger, btsd_pkg::LongFormBit});
  endtask

  task automatic test_strings;
    send_seq('{btsd_pkg::TagOctets, 8'h00});
    send_seq('{btsd_pkg::TagOctets, 8'h03, 8'h00, 8'hFF, 8'h5A});
    send_seq('{btsd_pkg::TagOctets, 8'h81, 8'h00});
    send_seq('{btsd_pkg::TagOctets, 8'h84, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAA, 8'h55});
  endtask

  task automatic test_string_limit;
    set_max_len(32'd0);
    send_seq('{btsd_pkg::TagOctets, 8'h00});
    send_seq('{btsd_pkg::TagOctets, 8'h01, 8'hAA});
    set_max_len(32'd2);
    send_seq('{btsd_pkg::TagOctets, 8'h02, 8'h11, 8'h22});
    send_seq('{btsd_pkg::TagOctets, 8'h03, 8'h11, 8'h22, 8'h33});
    set_max_len(32'hFFFF_FFFF);
  endtask

  task automatic test_null_and_other;
    send_seq('{btsd_pkg::TagNull, 8'h00});
    send_seq('{btsd_pkg::TagNull, 8'h02, 8'h11, 8'h22});
    send_seq('{8'h30, 8'h00});
    send_seq('{8'h30, 8'h03, 8'h01, 8'h02, 8'h03});
    send_seq('{8'hFF, 8'h01, 8'h00});
    send_seq('{8'h00, 8'h00});
  endtask

  task automatic test_length_errors;
    send_seq('{btsd_pkg::TagInteger, 8'h85, btsd_pkg::TagNull, 8'h00});
    send_seq('{btsd_pkg::TagOctets, 8'hFF, 8'h30, 8'h00});
  endtask

  task automatic test_random_stream;
    logic [31:0] limits[4];
    int target;
    limits[0] = 32'hFFFF_FFFF;
    limits[1] = 32'd0;
    limits[2] = $urandom_range(1, 8);
    limits[3] = 32'd3;
    target = bytes_sent;
    foreach (limits[i]) begin
      set_max_len(limits[i]);
      target += 250;
      while (bytes_sent < target) send_random_element();
    end
    set_max_len(32'hFFFF_FFFF);
  endtask

  // leaves the decoder skipping a huge body, so it runs last
  task automatic test_huge_length;
    send_seq('{btsd_pkg::TagInteger, 8'h84, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34});
  endtask

  // result checker and receiver stall pattern
  int   rx_cnt;
  int   rx_mode;
  int   stall_left;
  btsd_pkg::res_t got;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.event_res = out_if.event_res;
      got.elem_tag = out_if.elem_tag;
      got.value = out_if.value;
      got.elem_length = out_if.elem_length;
      got.last = out_if.last;
      if (pending_events.size() == 0) begin
        $error("unexpected result item: event_res %0d elem_tag %0h", got.event_res,
               got.elem_tag);
        fail_count++;
      end else begin
        if (got.event_res !== pending_events[0].event_res) begin
          $error("event_res: expected %0d, got %0d", pending_events[0].event_res,
                 got.event_res);
          fail_count++;
        end
        if (got.elem_tag !== pending_events[0].elem_tag) begin
          $error("elem_tag: expected %0h, got %0h", pending_events[0].elem_tag, got.elem_tag);
          fail_count++;
        end
        if (got.value !== pending_events[0].value) begin
          $error("value: expected %0h, got %0h", pending_events[0].value, got.value);
          fail_count++;
        end
        if (got.elem_length !== pending_events[0].elem_length) begin
          $error("elem_length: expected %0h, got %0h", pending_events[0].elem_length,
                 got.elem_length);
          fail_count++;
        end
        if (got.last !== pending_events[0].last) begin
          $error("last: expected %0d, got %0d", pending_events[0].last, got.last);
          fail_count++;
        end
        void'(pending_events.pop_front());
      end
    end
    rx_cnt++;
    if (rx_cnt % 128 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= (rx_cnt % 4 == 0);
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_if.ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_left = $urandom_range(1, 12);
          out_if.ready <= 1'b0;
        end else begin
          out_if.ready <= 1'b1;
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.max_string_len = '0;
    ph = btsd_pkg::PhTag;
    cur_tag = '0;
    len_bytes_left = '0;
    cur_len = '0;
    bytes_left = '0;
    acc = '0;
    skipping = 1'b0;
    max_str_len = 32'hFFFF_FFFF;
    fail_count = 0;
    bytes_sent = 0;
    cycles = 0;
    burst_left = 0;
    in_active = 1'b0;
    rx_cnt = 0;
    rx_mode = 0;
    stall_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_integers();
    test_strings();
    test_string_limit();
    test_null_and_other();
    test_length_errors();
    test_random_stream();
    test_huge_length();
    drain();

    if (fail_count == 0 && pending_events.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/btsd_pkg.sv
hdl/btsd_ifs.sv
hdl/btsd_core.sv
hdl/btsd_outreg.sv
hdl/ber_tlv_stream_decoder.sv
hdl/btsd_checker.sv
sim/ber_tlv_stream_decoder_test.sv
